>>> hw/rtl/memory_budget_watermark_monitor_unit_assert.svh
// Assertion macros for the checker file mbwm_checker.sv.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MEMORY_BUDGET_WATERMARK_MONITOR_UNIT_ASSERT_SVH
`define MEMORY_BUDGET_WATERMARK_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define MBWM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbwm assertion failed");

// Next-cycle implication
`define MBWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbwm assertion failed");

`endif

>>> hw/rtl/mbwm_pkg.sv
`timescale 1ns / 1ps
package mbwm_pkg;

  localparam int TOTAL_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int LVL_W     = 2;
  localparam int NUM_LVL   = 3;

  // Commands
  localparam logic [1:0] CMD_ALLOC     = 2'd0;
  localparam logic [1:0] CMD_FREE      = 2'd1;
  localparam logic [1:0] CMD_CHK_ALLOC = 2'd2;
  localparam logic [1:0] CMD_CHK_FREE  = 2'd3;

  // Watermark levels
  localparam logic [LVL_W-1:0] LVL_LOW  = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MED  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_HIGH = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_RISE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_FALL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MED_RISE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MED_FALL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_RISE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_FALL  = 3'd6;

  localparam logic [TOTAL_W-1:0] LIMIT_UNLIMITED = '1;

  typedef struct packed {
    logic [TOTAL_W-1:0] memory_limit;
    logic [TOTAL_W-1:0] high_rise;
    logic [TOTAL_W-1:0] high_fall;
    logic [TOTAL_W-1:0] med_rise;
    logic [TOTAL_W-1:0] med_fall;
    logic [TOTAL_W-1:0] low_rise;
    logic [TOTAL_W-1:0] low_fall;
  } cfg_t;

  typedef struct packed {
    logic               admitted;
    logic               event_valid;
    logic [LVL_W-1:0]   event_level;
    logic               event_rising;
    logic [TOTAL_W-1:0] current_total;
  } rsp_t;

endpackage

>>> hw/rtl/mbwm_if.sv
`timescale 1ns / 1ps
// Request channel: one command per transaction
interface mbwm_req_if;
  import mbwm_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [TOTAL_W-1:0] request_size;
  modport source (output valid, command, request_size, input ready);
  modport sink   (input valid, command, request_size, output ready);
endinterface

// Result channel: one result per request
interface mbwm_rsp_if;
  import mbwm_pkg::*;
  logic               valid;
  logic               ready;
  logic               admitted;
  logic               event_valid;
  logic [LVL_W-1:0]   event_level;
  logic               event_rising;
  logic [TOTAL_W-1:0] current_total;
  modport source (output valid, admitted, event_valid, event_level, event_rising,
                  current_total, input ready);
  modport sink   (input valid, admitted, event_valid, event_level, event_rising,
                  current_total, output ready);
endinterface

// Register write channel
interface mbwm_cfg_if;
  import mbwm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TOTAL_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/mbwm_cfg_regs.sv
`timescale 1ns / 1ps
module mbwm_cfg_regs
  import mbwm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  mbwm_cfg_if.sink        cfg,
  output cfg_t            cfg_o
);

  cfg_t cfg_r;

  // Always take register writes
  assign cfg.ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.memory_limit <= LIMIT_UNLIMITED;
      cfg_r.high_rise    <= '0;
      cfg_r.high_fall    <= '0;
      cfg_r.med_rise     <= '0;
      cfg_r.med_fall     <= '0;
      cfg_r.low_rise     <= '0;
      cfg_r.low_fall     <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LIMIT:     cfg_r.memory_limit <= cfg.data;
        REG_HIGH_RISE: cfg_r.high_rise    <= cfg.data;
        REG_HIGH_FALL: cfg_r.high_fall    <= cfg.data;
        REG_MED_RISE:  cfg_r.med_rise     <= cfg.data;
        REG_MED_FALL:  cfg_r.med_fall     <= cfg.data;
        REG_LOW_RISE:  cfg_r.low_rise     <= cfg.data;
        REG_LOW_FALL:  cfg_r.low_fall     <= cfg.data;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/mbwm_eval.sv
`timescale 1ns / 1ps
module mbwm_eval
  import mbwm_pkg::*;
(
  input  logic [1:0]         cmd,
  input  logic [TOTAL_W-1:0] size,
  input  logic [TOTAL_W-1:0] total,
  input  logic [NUM_LVL-1:0] flags,
  input  cfg_t               cfg,
  output logic [TOTAL_W-1:0] total_nxt,
  output logic [NUM_LVL-1:0] flags_nxt,
  output rsp_t               rsp
);

  logic [TOTAL_W:0] sum;
  logic             unlimited;
  logic             hit;
  logic [LVL_W-1:0] lvl;

  assign sum       = {1'b0, total} + {1'b0, size};
  assign unlimited = (cfg.memory_limit == LIMIT_UNLIMITED);

  always_comb begin
    total_nxt         = total;
    flags_nxt         = flags;
    hit               = 1'b0;
    lvl               = LVL_LOW;
    rsp.admitted      = 1'b0;
    rsp.event_rising  = 1'b0;
    case (cmd)
      CMD_ALLOC: begin
        // Admit within limit; saturate only reachable when unlimited
        if (unlimited || (sum <= {1'b0, cfg.memory_limit})) begin
          rsp.admitted = 1'b1;
          total_nxt    = sum[TOTAL_W] ? LIMIT_UNLIMITED : sum[TOTAL_W-1:0];
        end
      end
      CMD_FREE: begin
        total_nxt = (size >= total) ? '0 : total - size;
      end
      CMD_CHK_ALLOC: begin
        // Highest clear level whose rising threshold is exceeded
        if (!unlimited) begin
          if (total > cfg.high_rise && !flags[LVL_HIGH]) begin
            hit = 1'b1;
            lvl = LVL_HIGH;
          end else if (total > cfg.med_rise && !flags[LVL_MED]) begin
            hit = 1'b1;
            lvl = LVL_MED;
          end else if (total > cfg.low_rise && !flags[LVL_LOW]) begin
            hit = 1'b1;
            lvl = LVL_LOW;
          end
          if (hit) begin
            rsp.event_rising = 1'b1;
            case (lvl)
              LVL_HIGH: flags_nxt = 3'b111;
              LVL_MED:  flags_nxt = flags | 3'b011;
              default:  flags_nxt = flags | 3'b001;
            endcase
          end
        end
      end
      CMD_CHK_FREE: begin
        // Lowest set level whose falling threshold is undercut
        if (!unlimited) begin
          if (total < cfg.low_fall && flags[LVL_LOW]) begin
            hit = 1'b1;
            lvl = LVL_LOW;
          end else if (total < cfg.med_fall && flags[LVL_MED]) begin
            hit = 1'b1;
            lvl = LVL_MED;
          end else if (total < cfg.high_fall && flags[LVL_HIGH]) begin
            hit = 1'b1;
            lvl = LVL_HIGH;
          end
          if (hit) begin
            case (lvl)
              LVL_HIGH: flags_nxt = flags & 3'b011;
              LVL_MED:  flags_nxt = flags & 3'b001;
              default:  flags_nxt = 3'b000;
            endcase
          end
        end
      end
      default: begin
      end
    endcase
    rsp.event_valid   = hit;
    rsp.event_level   = lvl;
    rsp.current_total = total_nxt;
  end

endmodule

>>> hw/rtl/memory_budget_watermark_monitor_unit.sv
`timescale 1ns / 1ps
// Memory budget watermark monitor.
// in_if  : request transactions (command, request_size); allocate, free,
//          check after alloc, check after free.
// out_if : one result transaction per request (admitted, event fields and
//          the byte total after the request), in request order.
// cfg_if : register writes (index, data); always ready. Write only while no
//          request is in flight; the block itself does not enforce it.
// Pipeline: a request accepted on in_if enters the request stage, then
// moves into the result register and is shown on out_if. One stage holds
// the request, the second holds the result.
// Throughput: one request per cycle while out_if is not stalled. The running total and level flags
// update in the cycle the request moves into the result register, so
// every request sees the state left by the one before it.
// Reset: total and level flags clear, limit reads all ones (unlimited),
// thresholds clear, both stages empty.
// Stall: while out_if.ready is low the result holds, the request stage
// fills and then in_if.ready drops; nothing is lost or repeated.
module memory_budget_watermark_monitor_unit
  import mbwm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  mbwm_req_if.sink  in_if,
  mbwm_rsp_if.source out_if,
  mbwm_cfg_if.sink  cfg_if
);

  cfg_t               cfg;
  logic               in_v_r;
  logic [1:0]         cmd_r;
  logic [TOTAL_W-1:0] size_r;
  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] total_nxt;
  logic [NUM_LVL-1:0] flags_r;
  logic [NUM_LVL-1:0] flags_nxt;
  logic               out_v_r;
  rsp_t               rsp;
  rsp_t               rsp_r;
  logic               adv;
  logic               fire;
  logic               in_ready;

  mbwm_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_if),
    .cfg_o (cfg)
  );

  mbwm_eval u_eval (
    .cmd       (cmd_r),
    .size      (size_r),
    .total     (total_r),
    .flags     (flags_r),
    .cfg       (cfg),
    .total_nxt (total_nxt),
    .flags_nxt (flags_nxt),
    .rsp       (rsp)
  );

  // Handshake: result register frees up, request stage follows
  assign adv      = !out_v_r || out_if.ready;
  assign fire     = in_v_r && adv;
  assign in_ready = !in_v_r || adv;
  assign in_if.ready = in_ready;

  // Request stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_ready) begin
      cmd_r  <= in_if.command;
      size_r <= in_if.request_size;
    end
  end

  // Running state advances once per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      flags_r <= '0;
    end else if (fire) begin
      total_r <= total_nxt;
      flags_r <= flags_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_r <= rsp;
    end
  end

  assign out_if.valid         = out_v_r;
  assign out_if.admitted      = rsp_r.admitted;
  assign out_if.event_valid   = rsp_r.event_valid;
  assign out_if.event_level   = rsp_r.event_level;
  assign out_if.event_rising  = rsp_r.event_rising;
  assign out_if.current_total = rsp_r.current_total;

endmodule

>>> hw/rtl/mbwm_checker.sv
`timescale 1ns / 1ps
`include "memory_budget_watermark_monitor_unit_assert.svh"
module mbwm_checker
  import mbwm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               admitted,
  input logic               event_valid,
  input logic [LVL_W-1:0]   event_level,
  input logic               event_rising,
  input logic [TOTAL_W-1:0] current_total
);

  // Stalled result holds
  `MBWM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(current_total))

  // An empty result register never blocks requests
  `MBWM_ASSERT_SAME(a_in_ready_when_empty, !out_valid, in_ready)

  // Events come only from checks, never with an admission, at a real level
  `MBWM_ASSERT_SAME(a_event_excl, out_valid && event_valid,
                    !admitted && event_level != 2'd3)

  // No event means cleared event fields
  `MBWM_ASSERT_SAME(a_no_event_clear, out_valid && !event_valid,
                    !event_rising && event_level == LVL_LOW)

endmodule

bind memory_budget_watermark_monitor_unit mbwm_checker u_mbwm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .admitted      (out_if.admitted),
  .event_valid   (out_if.event_valid),
  .event_level   (out_if.event_level),
  .event_rising  (out_if.event_rising),
  .current_total (out_if.current_total)
);

>>> verif/memory_budget_watermark_monitor_unit_tb.sv
`timescale 1ns / 1ps

// Tracks the byte total, level flags and register values, and holds the
// responses still owed by the block in request order.
class budget_ledger;
  logic [31:0]       limit;
  logic [31:0]       rise_thr [3];
  logic [31:0]       fall_thr [3];
  logic [31:0]       total;
  logic [2:0]        level_flags;
  mbwm_pkg::rsp_t    due_responses [$];
  int                mismatches;
  int                requests;
  int                admits;
  int                crossings;

  function new();
    limit       = mbwm_pkg::LIMIT_UNLIMITED;
    rise_thr    = '{default: '0};
    fall_thr    = '{default: '0};
    total       = '0;
    level_flags = '0;
    mismatches  = 0;
    requests    = 0;
    admits      = 0;
    crossings   = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      mbwm_pkg::REG_LIMIT:     limit = data;
      mbwm_pkg::REG_HIGH_RISE: rise_thr[mbwm_pkg::LVL_HIGH] = data;
      mbwm_pkg::REG_HIGH_FALL: fall_thr[mbwm_pkg::LVL_HIGH] = data;
      mbwm_pkg::REG_MED_RISE:  rise_thr[mbwm_pkg::LVL_MED] = data;
      mbwm_pkg::REG_MED_FALL:  fall_thr[mbwm_pkg::LVL_MED] = data;
      mbwm_pkg::REG_LOW_RISE:  rise_thr[mbwm_pkg::LVL_LOW] = data;
      mbwm_pkg::REG_LOW_FALL:  fall_thr[mbwm_pkg::LVL_LOW] = data;
      default: ;
    endcase
  endfunction

  // Advance the budget state for one accepted request and queue its response
  function void account_request(logic [1:0] cmd, logic [31:0] size);
    mbwm_pkg::rsp_t exp;
    logic [32:0]    sum;
    bit             unlimited;
    int             hit;
    int             lvl;
    exp       = '0;
    hit       = -1;
    unlimited = (limit == mbwm_pkg::LIMIT_UNLIMITED);
    sum       = {1'b0, total} + {1'b0, size};
    case (cmd)
      mbwm_pkg::CMD_ALLOC: begin
        // 33-bit compare never wraps; unlimited add saturates at all ones
        if (unlimited || sum <= {1'b0, limit}) begin
          exp.admitted = 1'b1;
          total        = sum[32] ? '1 : sum[31:0];
          admits++;
        end
      end
      mbwm_pkg::CMD_FREE: begin
        total = (size >= total) ? '0 : total - size;
      end
      mbwm_pkg::CMD_CHK_ALLOC: begin
        if (!unlimited) begin
          // highest clear level whose rising threshold is exceeded
          for (lvl = mbwm_pkg::NUM_LVL - 1; lvl >= 0; lvl--)
            if (hit < 0 && total > rise_thr[lvl] && !level_flags[lvl]) hit = lvl;
          if (hit >= 0) begin
            exp.event_rising = 1'b1;
            level_flags      = level_flags | 3'((2 << hit) - 1);
          end
        end
      end
      default: begin
        if (!unlimited) begin
          // lowest set level whose falling threshold is above the total
          for (lvl = 0; lvl < mbwm_pkg::NUM_LVL; lvl++)
            if (hit < 0 && total < fall_thr[lvl] && level_flags[lvl]) hit = lvl;
          if (hit >= 0) level_flags = level_flags & 3'((1 << hit) - 1);
        end
      end
    endcase
    if (hit >= 0) begin
      exp.event_valid = 1'b1;
      exp.event_level = hit[1:0];
      crossings++;
    end
    exp.current_total = total;
    due_responses.push_back(exp);
    requests++;
  endfunction

  // Compare one response with the oldest one owed
  function void match_response(mbwm_pkg::rsp_t got);
    mbwm_pkg::rsp_t exp;
    if (due_responses.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR %0t: response with no pending request: adm=%b ev=%b lvl=%0d rise=%b tot=%h",
                 $time, got.admitted, got.event_valid, got.event_level, got.event_rising,
                 got.current_total);
      return;
    end
    exp = due_responses.pop_front();
    if (got.admitted !== exp.admitted || got.event_valid !== exp.event_valid ||
        got.event_level !== exp.event_level || got.event_rising !== exp.event_rising ||
        got.current_total !== exp.current_total) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR %0t: expected adm=%b ev=%b lvl=%0d rise=%b tot=%h, got adm=%b ev=%b lvl=%0d rise=%b tot=%h",
                 $time, exp.admitted, exp.event_valid, exp.event_level, exp.event_rising,
                 exp.current_total, got.admitted, got.event_valid, got.event_level,
                 got.event_rising, got.current_total);
    end
  endfunction
endclass

module memory_budget_watermark_monitor_unit_tb;
  import mbwm_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 180;
  localparam int RANDOM_PHASES = 8;

  logic clk = 1'b0;
  logic rst_n;

  mbwm_req_if req_ch ();
  mbwm_rsp_if rsp_ch ();
  mbwm_cfg_if cfg_ch ();

  memory_budget_watermark_monitor_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (rsp_ch),
    .cfg_if (cfg_ch)
  );

  budget_ledger   ledger = new();
  rsp_t           seen_rsp;
  int             gap_pct   = 0;
  int             stall_pct = 0;
  int             quiet_cycles = 0;
  int             settings_count = 0;
  int             total_errors;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Randomly stall the response channel
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Observe transactions on all three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen_rsp.admitted      = rsp_ch.admitted;
        seen_rsp.event_valid   = rsp_ch.event_valid;
        seen_rsp.event_level   = rsp_ch.event_level;
        seen_rsp.event_rising  = rsp_ch.event_rising;
        seen_rsp.current_total = rsp_ch.current_total;
        ledger.match_response(seen_rsp);
      end
      if (req_ch.valid && req_ch.ready)
        ledger.account_request(req_ch.command, req_ch.request_size);
      if (cfg_ch.valid && cfg_ch.ready)
        ledger.write_reg(cfg_ch.index, cfg_ch.data);
    end
  end

  // End the run if no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [1:0] cmd, input logic [31:0] size);
    while ($urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.command      <= cmd;
    req_ch.request_size <= size;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold requests until every owed response has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (ledger.due_responses.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] lim, input logic [31:0] hr,
                                input logic [31:0] hf, input logic [31:0] mr,
                                input logic [31:0] mf, input logic [31:0] lr,
                                input logic [31:0] lf);
    wait_drained();
    put_reg(REG_LIMIT, lim);
    put_reg(REG_HIGH_RISE, hr);
    put_reg(REG_HIGH_FALL, hf);
    put_reg(REG_MED_RISE, mr);
    put_reg(REG_MED_FALL, mf);
    put_reg(REG_LOW_RISE, lr);
    put_reg(REG_LOW_FALL, lf);
    cfg_ch.valid <= 1'b0;
    settings_count++;
  endtask

  function automatic logic [31:0] pct_of(logic [31:0] scale, int pct);
    logic [63:0] prod;
    prod = {32'b0, scale} * pct;
    return 32'(prod / 100);
  endfunction

  function automatic logic [31:0] pick_size(logic [31:0] scale);
    case ($urandom_range(9))
      0:       return '0;
      1:       return $urandom;
      default: return $urandom_range(0, scale / 6 + 1);
    endcase
  endfunction

  initial begin
    logic [31:0] lim;
    logic [31:0] scale;
    logic [31:0] size;
    logic [31:0] hr, hf, mr, mf, lr, lf;
    logic [1:0]  cmd;
    int          r;
    int          phase_items;

    rst_n               = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.command      = CMD_ALLOC;
    req_ch.request_size = '0;
    rsp_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_LIMIT;
    cfg_ch.data         = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Unlimited after reset: checks skipped, add saturates, free saturates
    send_request(CMD_ALLOC, 32'h0);
    send_request(CMD_ALLOC, 32'hFFFF_FFFF);
    send_request(CMD_ALLOC, 32'h5);
    send_request(CMD_CHK_ALLOC, 32'hFFFF_FFFF);
    send_request(CMD_CHK_FREE, 32'h0);
    send_request(CMD_FREE, 32'hFFFF_FFFF);
    send_request(CMD_FREE, 32'd10);

    // Small budget with nested watermarks
    apply_settings(32'd1000, 32'd800, 32'd700, 32'd500, 32'd400, 32'd200, 32'd100);
    send_request(CMD_ALLOC, 32'd1000);
    send_request(CMD_ALLOC, 32'd1);
    send_request(CMD_ALLOC, 32'hFFFF_FFFF);
    send_request(CMD_CHK_ALLOC, 32'h0);
    send_request(CMD_CHK_ALLOC, 32'h0);
    send_request(CMD_FREE, 32'd650);
    send_request(CMD_CHK_FREE, 32'h0);
    send_request(CMD_CHK_FREE, 32'h0);
    send_request(CMD_FREE, 32'd300);
    send_request(CMD_CHK_FREE, 32'h0);
    send_request(CMD_ALLOC, 32'd250);
    send_request(CMD_CHK_ALLOC, 32'h0);
    send_request(CMD_ALLOC, 32'd300);
    send_request(CMD_CHK_ALLOC, 32'h0);
    send_request(CMD_ALLOC, 32'd0);
    send_request(CMD_FREE, 32'd5000);
    send_request(CMD_CHK_FREE, 32'h0);

    // Random phases: each with its own settings and pacing
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       lim = '0;
        1:       lim = 32'hFFFF_FFFE;
        2:       lim = LIMIT_UNLIMITED;
        7:       lim = $urandom;
        default: lim = $urandom_range(256, 1 << 24);
      endcase
      scale = (lim == '0 || lim == LIMIT_UNLIMITED) ? $urandom_range(4096, 1 << 20) : lim;
      if (phase == 3) begin
        hr = '1; hf = '0; mr = '0; mf = '1; lr = '0; lf = '1;
      end else begin
        hr = pct_of(scale, $urandom_range(70, 92));
        hf = pct_of(scale, $urandom_range(55, 75));
        mr = pct_of(scale, $urandom_range(40, 60));
        mf = pct_of(scale, $urandom_range(25, 45));
        lr = pct_of(scale, $urandom_range(15, 30));
        lf = pct_of(scale, $urandom_range(2, 20));
      end
      apply_settings(lim, hr, hf, mr, mf, lr, lf);

      case (phase % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 54; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 54; end
        default: begin gap_pct = 20; stall_pct = 20; end
      endcase

      // Start from an empty budget so small limits can admit
      send_request(CMD_FREE, 32'hFFFF_FFFF);
      phase_items = 1;
      while (phase_items < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 40) begin
          cmd  = CMD_ALLOC;
          size = pick_size(scale);
        end else if (r < 65) begin
          cmd  = CMD_FREE;
          size = pick_size(scale);
        end else if (r < 78) begin
          cmd  = CMD_CHK_ALLOC;
          size = $urandom;
        end else if (r < 90) begin
          cmd  = CMD_CHK_FREE;
          size = $urandom;
        end else begin
          cmd  = 2'($urandom_range(3));
          size = $urandom;
        end
        send_request(cmd, size);
        phase_items++;
        // Follow an allocation or a free with its matching check
        if ((cmd == CMD_ALLOC || cmd == CMD_FREE) && $urandom_range(99) < 60) begin
          send_request((cmd == CMD_ALLOC) ? CMD_CHK_ALLOC : CMD_CHK_FREE, $urandom);
          phase_items++;
        end
        if ($urandom_range(199) == 0) wait_drained();
      end
    end

    // Let the pipeline empty, then settle
    gap_pct   = 0;
    stall_pct = 0;
    wait_drained();
    repeat (10) @(negedge clk);

    total_errors = ledger.mismatches + ledger.due_responses.size();
    if (ledger.due_responses.size() != 0)
      $display("ERROR: %0d responses never arrived", ledger.due_responses.size());
    $display("Covered %0d requests: %0d admitted allocations, %0d watermark crossings",
             ledger.requests, ledger.admits, ledger.crossings);
    $display("across %0d register settings and four pacing modes; %0d mismatches",
             settings_count, ledger.mismatches);
    if (total_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
